@@ design/lci_pkg.sv @@
`timescale 1ns / 1ps
package lci_pkg;

  // word widths
  localparam int CW      = 32;   // coordinate word
  localparam int RADW    = 31;   // radius word
  localparam int X0W     = 33;   // point minus centre
  localparam int AW      = 64;   // A = dx^2 + dy^2
  localparam int HW      = 66;   // H, signed
  localparam int HMW     = 65;   // |H|
  localparam int CCW     = 67;   // C, signed
  localparam int CMW     = 66;   // |C|
  localparam int PW      = 130;  // H^2 and A*|C|
  localparam int DW      = 131;  // quarter discriminant, signed
  localparam int DMW     = 130;  // discriminant magnitude

  // square root: radicand D * 2^64, two bits per stage
  localparam int GUARD   = 32;
  localparam int SQ_STAGES = (DMW + 2 * GUARD) / 2;
  localparam int ROOTW   = SQ_STAGES;
  localparam int REMW    = ROOTW + 2;

  // numerators and division
  localparam int NUMW    = 100;  // -H*2^32 +/- S, signed
  localparam int NMW     = 99;   // magnitude, three 33-bit limbs
  localparam int LIMB    = 33;
  localparam int PPW     = CW + LIMB;
  localparam int TW      = 131;  // |dir * num|
  localparam int NNW     = 100;  // rounded dividend over 2^32
  localparam int QUO_BITS = 34;
  localparam int SUMW    = QUO_BITS + 3;
  localparam int DIV_LAT = QUO_BITS + 6;

  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_ONE,
    CNT_TWO
  } count_t;

  typedef struct packed {
    logic signed [CW-1:0]   line_px;
    logic signed [CW-1:0]   line_py;
    logic signed [CW-1:0]   line_dx;
    logic signed [CW-1:0]   line_dy;
    logic signed [CW-1:0]   center_x;
    logic signed [CW-1:0]   center_y;
    logic        [RADW-1:0] radius;
  } query_t;

  typedef struct packed {
    logic        [1:0]    point_count;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic                 clipped;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
  } geo_t;

  typedef struct packed {
    geo_t                 geo;
    logic        [AW-1:0] a;
    logic signed [HW-1:0] h;
    count_t               count;
  } side_t;

endpackage

@@ design/lci_coef.sv @@
`timescale 1ns / 1ps
module lci_coef (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  lci_pkg::query_t         query,
  output logic                    out_valid,
  output lci_pkg::side_t          side,
  output logic [lci_pkg::DMW-1:0] dmag
);
  import lci_pkg::*;

  localparam int NST = 8;

  logic [NST-1:0] vld;
  geo_t geo [NST-1];

  logic signed [X0W-1:0]  x0, y0;
  logic        [RADW-1:0] r1;

  logic signed [2*CW-1:0]  aa1, aa2;
  logic signed [CW+X0W-1:0] hh1, hh2;
  logic signed [2*X0W-1:0] cc1, cc2;
  logic        [2*RADW-1:0] rr;

  logic        [AW-1:0]  a3, a4, a5, a6, a7;
  logic signed [HW-1:0]  h3, h4, h5, h6, h7;
  logic signed [CCW-1:0] c3;

  logic [HMW-1:0] hm;
  logic [CMW-1:0] cm;
  logic           cneg4, cneg5, cneg6;
  logic           az4, az5, az6, az7;

  logic [2*(HMW-32)-1:0]     p_hh;
  logic [HMW-1:0]            p_hl;
  logic [63:0]               p_ll;
  logic [32+CMW-32-1:0]      q_hh, q_lh;
  logic [63:0]               q_hl, q_ll;

  logic [PW-1:0] h2, ac;
  logic [DW-1:0] d7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  assign out_valid = vld[NST-1];

  // geometry travels alongside the arithmetic
  always_ff @(posedge clk) begin
    geo[0] <= '{px: query.line_px, py: query.line_py,
                dx: query.line_dx, dy: query.line_dy};
    for (int k = 1; k < NST - 1; k++) begin
      geo[k] <= geo[k-1];
    end
  end

  always_ff @(posedge clk) begin
    // s1: offsets from centre
    x0 <= X0W'(query.line_px) - X0W'(query.center_x);
    y0 <= X0W'(query.line_py) - X0W'(query.center_y);
    r1 <= query.radius;
    // s2: single products
    aa1 <= geo[0].dx * geo[0].dx;
    aa2 <= geo[0].dy * geo[0].dy;
    hh1 <= geo[0].dx * x0;
    hh2 <= geo[0].dy * y0;
    cc1 <= x0 * x0;
    cc2 <= y0 * y0;
    rr  <= r1 * r1;
    // s3: coefficients
    a3 <= AW'(aa1) + AW'(aa2);
    h3 <= HW'(hh1) + HW'(hh2);
    c3 <= CCW'(cc1) + CCW'(cc2) - CCW'(rr);
    // s4: magnitudes for the wide products
    hm    <= h3[HW-1] ? HMW'(-h3) : HMW'(h3);
    cm    <= c3[CCW-1] ? CMW'(-c3) : CMW'(c3);
    cneg4 <= c3[CCW-1];
    az4   <= (a3 == '0);
    a4    <= a3;
    h4    <= h3;
    // s5: limb products
    p_hh  <= hm[HMW-1:32] * hm[HMW-1:32];
    p_hl  <= hm[HMW-1:32] * hm[31:0];
    p_ll  <= hm[31:0] * hm[31:0];
    q_hh  <= a4[63:32] * cm[CMW-1:32];
    q_hl  <= a4[63:32] * cm[31:0];
    q_lh  <= a4[31:0] * cm[CMW-1:32];
    q_ll  <= a4[31:0] * cm[31:0];
    cneg5 <= cneg4;
    az5   <= az4;
    a5    <= a4;
    h5    <= h4;
    // s6: H^2 and A*|C|
    h2 <= (PW'(p_hh) << 64) + (PW'(p_hl) << 33) + PW'(p_ll);
    ac <= (PW'(q_hh) << 64) + ((PW'(q_hl) + PW'(q_lh)) << 32) + PW'(q_ll);
    cneg6 <= cneg5;
    az6   <= az5;
    a6    <= a5;
    h6    <= h5;
    // s7: D = H^2 - A*C
    d7  <= cneg6 ? (DW'(h2) + DW'(ac)) : (DW'(h2) - DW'(ac));
    az7 <= az6;
    a7  <= a6;
    h7  <= h6;
    // s8: classify
    side.geo <= geo[NST-2];
    side.a   <= a7;
    side.h   <= h7;
    if (az7 || d7[DW-1]) begin
      side.count <= CNT_NONE;
    end else if (d7 == '0) begin
      side.count <= CNT_ONE;
    end else begin
      side.count <= CNT_TWO;
    end
    dmag <= d7[DW-1] ? '0 : d7[DMW-1:0];
  end

endmodule

@@ design/lci_sqrt.sv @@
`timescale 1ns / 1ps
module lci_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  lci_pkg::side_t            side_in,
  input  logic [lci_pkg::DMW-1:0]   dmag,
  output logic                      out_valid,
  output lci_pkg::side_t            side_out,
  output logic [lci_pkg::ROOTW-1:0] root
);
  import lci_pkg::*;

  logic             vld [SQ_STAGES];
  side_t            sd  [SQ_STAGES];
  logic [DMW-1:0]   rad [SQ_STAGES];
  logic [REMW-1:0]  rem [SQ_STAGES];
  logic [ROOTW-1:0] rt  [SQ_STAGES];

  // one root bit per stage, radicand bits two at a time from the top
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic             pv;
    side_t            ps;
    logic [DMW-1:0]   prad;
    logic [REMW-1:0]  prem;
    logic [ROOTW-1:0] prt;
    logic [REMW+1:0]  rem_sh;
    logic [REMW+1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign ps   = side_in;
      assign prad = dmag;
      assign prem = '0;
      assign prt  = '0;
    end else begin : g_next
      assign pv   = vld[k-1];
      assign ps   = sd[k-1];
      assign prad = rad[k-1];
      assign prem = rem[k-1];
      assign prt  = rt[k-1];
    end

    assign rem_sh = {prem, prad[DMW-1:DMW-2]};
    assign trial  = (REMW+2)'({prt, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      sd[k]  <= ps;
      rad[k] <= {prad[DMW-3:0], 2'b00};
      rem[k] <= ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
      rt[k]  <= {prt[ROOTW-2:0], ge};
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign side_out  = sd[SQ_STAGES-1];
  assign root      = rt[SQ_STAGES-1];

endmodule

@@ design/lci_div.sv @@
`timescale 1ns / 1ps
module lci_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [lci_pkg::CW-1:0]   p,
  input  logic signed [lci_pkg::CW-1:0]   dir,
  input  logic signed [lci_pkg::NUMW-1:0] num,
  input  logic        [lci_pkg::AW-1:0]   a,
  output logic                            out_valid,
  output logic signed [lci_pkg::CW-1:0]   coord,
  output logic                            clip
);
  import lci_pkg::*;

  localparam int DST = QUO_BITS + 1;

  logic [3:0] vpre;

  logic signed [CW-1:0] p1, p2, p3, p4;
  logic [AW-1:0]        a1, a2, a3, a4;
  logic                 n1, n2, n3, n4;

  logic [CW-1:0]  dm;
  logic [NMW-1:0] nm;
  logic [PPW-1:0] pp0, pp1, pp2;
  logic [TW-1:0]  tm;
  logic [NNW-1:0] nn;

  logic                 dv  [DST];
  logic [NNW-1:0]       rem [DST];
  logic [QUO_BITS-1:0]  dq  [DST];
  logic [AW-1:0]        da  [DST];
  logic signed [CW-1:0] dp  [DST];
  logic                 dn  [DST];
  logic                 dov [DST];

  logic signed [SUMW-1:0] sum;
  logic                   sum_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpre <= '0;
    end else begin
      vpre <= {vpre[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // d1: sign and magnitude
    dm <= dir[CW-1] ? CW'(-dir) : CW'(dir);
    nm <= num[NUMW-1] ? NMW'(-num) : NMW'(num);
    n1 <= dir[CW-1] ^ num[NUMW-1];
    p1 <= p;
    a1 <= a;
    // d2: limb products
    pp0 <= dm * nm[LIMB-1:0];
    pp1 <= dm * nm[2*LIMB-1:LIMB];
    pp2 <= dm * nm[3*LIMB-1:2*LIMB];
    n2  <= n1;
    p2  <= p1;
    a2  <= a1;
    // d3: |dir * num|
    tm <= TW'(pp0) + (TW'(pp1) << LIMB) + (TW'(pp2) << (2 * LIMB));
    n3 <= n2;
    p3 <= p2;
    a3 <= a2;
    // d4: add half the divisor, drop the guard scale
    nn <= NNW'(((TW+1)'(tm) + ((TW+1)'(a3) << (GUARD - 1))) >> GUARD);
    n4 <= n3;
    p4 <= p3;
    a4 <= a3;
  end

  // quotient beyond range always saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= vpre[3];
    end
  end

  always_ff @(posedge clk) begin
    dov[0] <= (nn >= (NNW'(a4) << QUO_BITS));
    rem[0] <= nn;
    dq[0]  <= '0;
    da[0]  <= a4;
    dp[0]  <= p4;
    dn[0]  <= n4;
  end

  for (genvar j = 1; j < DST; j++) begin : g_step
    logic [NNW-1:0] sub;
    logic           ge;

    assign sub = NNW'(da[j-1]) << (QUO_BITS - j);
    assign ge  = (rem[j-1] >= sub);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else begin
        dv[j] <= dv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem[j] <= ge ? (rem[j-1] - sub) : rem[j-1];
      dq[j]  <= {dq[j-1][QUO_BITS-2:0], ge};
      da[j]  <= da[j-1];
      dp[j]  <= dp[j-1];
      dn[j]  <= dn[j-1];
      dov[j] <= dov[j-1];
    end
  end

  // offset the start point, then saturate
  assign sum = dn[DST-1] ? (SUMW'(dp[DST-1]) - SUMW'(dq[DST-1]))
                         : (SUMW'(dp[DST-1]) + SUMW'(dq[DST-1]));
  assign sum_out = (sum[SUMW-1:CW-1] != {(SUMW-CW+1){sum[SUMW-1]}});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv[DST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (dov[DST-1]) begin
      coord <= dn[DST-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      clip  <= 1'b1;
    end else if (sum_out) begin
      coord <= sum[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      clip  <= 1'b1;
    end else begin
      coord <= sum[CW-1:0];
      clip  <= 1'b0;
    end
  end

endmodule

@@ design/line_circle_intersection.sv @@
`timescale 1ns / 1ps
// A transaction passes the coefficient, square root, numerator, divide and output
// stages in that order on its way to the done strobe.
// Throughput: one transaction per cycle; every stage is a fixed pipeline
// step and the receiver cannot stall, so busy is only high during reset.
// Reset (rst, synchronous): clears all valid bits; data registers keep contents.
module line_circle_intersection (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lci_pkg::query_t  query,
  output logic             done,
  output lci_pkg::result_t result
);
  import lci_pkg::*;

  // transaction taken on start while not busy
  logic  take;

  // coefficient and discriminant pipeline
  logic           cf_valid;
  side_t          cf_side;
  logic [DMW-1:0] cf_dmag;

  // integer floor root of D * 2^64
  logic             sq_valid;
  side_t            sq_side;
  logic [ROOTW-1:0] sq_root;

  // numerators for both roots
  logic                   nu_valid;
  side_t                  nu_side;
  logic signed [NUMW-1:0] nu_lo, nu_hi;
  logic signed [NUMW-1:0] h_sh;

  // divide lanes: first x, first y, second x, second y
  logic                 lane_valid [4];
  logic signed [CW-1:0] lane_coord [4];
  logic                 lane_clip  [4];

  // point count travels beside the divide lanes
  count_t cnt_line [DIV_LAT];

  // assembled result ahead of the output register
  result_t result_next;

  assign busy = rst;
  assign take = start & ~busy;

  lci_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .query     (query),
    .out_valid (cf_valid),
    .side      (cf_side),
    .dmag      (cf_dmag)
  );

  lci_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cf_valid),
    .side_in   (cf_side),
    .dmag      (cf_dmag),
    .out_valid (sq_valid),
    .side_out  (sq_side),
    .root      (sq_root)
  );

  // lower t numerator is -(H*2^32 + S), upper is S - H*2^32;
  // for a tangent S is zero and both give the same point
  assign h_sh = NUMW'(sq_side.h) <<< GUARD;

  always_ff @(posedge clk) begin
    if (rst) begin
      nu_valid <= 1'b0;
    end else begin
      nu_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    nu_side <= sq_side;
    nu_lo   <= -(h_sh + NUMW'(sq_root));
    nu_hi   <= NUMW'(sq_root) - h_sh;
  end

  lci_div u_div_fx (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nu_valid),
    .p         (nu_side.geo.px),
    .dir       (nu_side.geo.dx),
    .num       (nu_lo),
    .a         (nu_side.a),
    .out_valid (lane_valid[0]),
    .coord     (lane_coord[0]),
    .clip      (lane_clip[0])
  );

  lci_div u_div_fy (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nu_valid),
    .p         (nu_side.geo.py),
    .dir       (nu_side.geo.dy),
    .num       (nu_lo),
    .a         (nu_side.a),
    .out_valid (lane_valid[1]),
    .coord     (lane_coord[1]),
    .clip      (lane_clip[1])
  );

  lci_div u_div_sx (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nu_valid),
    .p         (nu_side.geo.px),
    .dir       (nu_side.geo.dx),
    .num       (nu_hi),
    .a         (nu_side.a),
    .out_valid (lane_valid[2]),
    .coord     (lane_coord[2]),
    .clip      (lane_clip[2])
  );

  lci_div u_div_sy (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nu_valid),
    .p         (nu_side.geo.py),
    .dir       (nu_side.geo.dy),
    .num       (nu_hi),
    .a         (nu_side.a),
    .out_valid (lane_valid[3]),
    .coord     (lane_coord[3]),
    .clip      (lane_clip[3])
  );

  always_ff @(posedge clk) begin
    cnt_line[0] <= nu_side.count;
    for (int k = 1; k < DIV_LAT; k++) begin
      cnt_line[k] <= cnt_line[k-1];
    end
  end

  // all lanes run in lockstep; done needs the valids of all four lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane_valid[0] & lane_valid[1] & lane_valid[2] & lane_valid[3];
    end
  end

  // unreported points and their clip flags read as zero
  always_comb begin
    result_next = '0;
    case (cnt_line[DIV_LAT-1])
      CNT_ONE: begin
        result_next.point_count = 2'(CNT_ONE);
        result_next.first_x     = lane_coord[0];
        result_next.first_y     = lane_coord[1];
        result_next.clipped     = lane_clip[0] | lane_clip[1];
      end
      CNT_TWO: begin
        result_next.point_count = 2'(CNT_TWO);
        result_next.first_x     = lane_coord[0];
        result_next.first_y     = lane_coord[1];
        result_next.second_x    = lane_coord[2];
        result_next.second_y    = lane_coord[3];
        result_next.clipped     = lane_clip[0] | lane_clip[1] |
                                  lane_clip[2] | lane_clip[3];
      end
      default: begin
        result_next.point_count = 2'(CNT_NONE);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ dv/line_circle_intersection_tb.sv @@
`timescale 1ns / 1ps
module line_circle_intersection_tb;
  import lci_pkg::*;

  // working width for the exact arithmetic: comfortably above the ~200 bits needed
  typedef logic signed [255:0] wide_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int ONE = 32'h0001_0000;  // 1.0 in Q16.16

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  query_t  query;
  logic    done;
  result_t result;

  result_t expected_results[$];
  int      error_count = 0;
  int      cycle_count = 0;

  line_circle_intersection dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .query(query),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // floor square root of a non-negative wide value, one bit at a time
  function automatic wide_t floor_sqrt(wide_t n);
    wide_t r;
    wide_t c;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      c = r | (wide_t'(1) <<< i);
      if ($unsigned(c * c) <= $unsigned(n)) r = c;
    end
    return r;
  endfunction

  // p + round(dir * num / den), ties away from zero, then saturate to 32 bits
  function automatic logic [CW-1:0] point_on_line(wide_t p, wide_t dir, wide_t num, wide_t den,
                                                   inout logic clip);
    wide_t prod;
    wide_t mag;
    wide_t quo;
    wide_t rem;
    wide_t sum;
    prod = dir * num;
    mag  = (prod < 0) ? -prod : prod;
    quo  = wide_t'($unsigned(mag) / $unsigned(den));
    rem  = wide_t'($unsigned(mag) % $unsigned(den));
    if ((rem <<< 1) >= den) quo = quo + 1;
    if (prod < 0) quo = -quo;
    sum = p + quo;
    if (sum > wide_t'(32'sh7fff_ffff)) begin
      clip = 1'b1;
      sum  = wide_t'(32'sh7fff_ffff);
    end
    if (sum < -wide_t'(64'sh8000_0000)) begin
      clip = 1'b1;
      sum  = -wide_t'(64'sh8000_0000);
    end
    return sum[CW-1:0];
  endfunction

  function automatic result_t intersect_predict(query_t q);
    result_t res;
    wide_t px, py, dx, dy, cx, cy, rad;
    wide_t x0, y0, a, h, c, d, den, nh, s;
    logic clip;
    res  = '0;
    clip = 1'b0;
    px  = wide_t'($signed(q.line_px));
    py  = wide_t'($signed(q.line_py));
    dx  = wide_t'($signed(q.line_dx));
    dy  = wide_t'($signed(q.line_dy));
    cx  = wide_t'($signed(q.center_x));
    cy  = wide_t'($signed(q.center_y));
    rad = wide_t'({1'b0, q.radius});
    x0 = px - cx;
    y0 = py - cy;
    a  = dx * dx + dy * dy;
    if (a == 0) return res;           // degenerate line: no direction
    h = dx * x0 + dy * y0;
    c = x0 * x0 + y0 * y0 - rad * rad;
    d = h * h - a * c;
    if (d < 0) return res;            // line misses the circle
    den = a <<< 32;
    nh  = (-h) <<< 32;
    if (d == 0) begin                 // tangent
      res.point_count = CNT_ONE;
      res.first_x = point_on_line(px, dx, nh, den, clip);
      res.first_y = point_on_line(py, dy, nh, den, clip);
    end else begin                    // secant, lower t first
      s = floor_sqrt(d <<< 64);
      res.point_count = CNT_TWO;
      res.first_x  = point_on_line(px, dx, nh - s, den, clip);
      res.first_y  = point_on_line(py, dy, nh - s, den, clip);
      res.second_x = point_on_line(px, dx, nh + s, den, clip);
      res.second_y = point_on_line(py, dy, nh + s, den, clip);
    end
    res.clipped = clip;
    return res;
  endfunction

  // mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // one transaction: hold start until accepted, then optionally idle
  task automatic send_query(query_t q, int gap);
    query <= q;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_results.push_back(intersect_predict(q));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // result checker: done is a one-cycle strobe, no back-pressure possible
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, result);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.point_count !== exp_r.point_count) begin
          $display("%0t: point_count expected %0d actual %0d", $time,
                   exp_r.point_count, result.point_count);
          error_count++;
        end
        if (result.first_x !== exp_r.first_x) begin
          $display("%0t: first_x expected %h actual %h", $time, exp_r.first_x, result.first_x);
          error_count++;
        end
        if (result.first_y !== exp_r.first_y) begin
          $display("%0t: first_y expected %h actual %h", $time, exp_r.first_y, result.first_y);
          error_count++;
        end
        if (result.second_x !== exp_r.second_x) begin
          $display("%0t: second_x expected %h actual %h", $time,
                   exp_r.second_x, result.second_x);
          error_count++;
        end
        if (result.second_y !== exp_r.second_y) begin
          $display("%0t: second_y expected %h actual %h", $time,
                   exp_r.second_y, result.second_y);
          error_count++;
        end
        if (result.clipped !== exp_r.clipped) begin
          $display("%0t: clipped expected %0b actual %0b", $time, exp_r.clipped, result.clipped);
          error_count++;
        end
      end
    end
  end

  function automatic query_t make_query(int px, int py, int dx, int dy, int cx, int cy,
                                        logic [RADW-1:0] r);
    query_t q;
    q.line_px  = px;
    q.line_py  = py;
    q.line_dx  = dx;
    q.line_dy  = dy;
    q.center_x = cx;
    q.center_y = cy;
    q.radius   = r;
    return q;
  endfunction

  // corner cases: miss, tangent, secant, zero direction, extremes, saturation
  task automatic test_directed();
    send_query(make_query(0, 2 * ONE, ONE, 0, 0, 0, ONE), 0);                 // miss
    send_query(make_query(0, ONE, ONE, 0, 0, 0, ONE), 0);                     // tangent
    send_query(make_query(ONE, 0, 0, -ONE, ONE, 0, ONE), 1);                  // vertical tangent-free
    send_query(make_query(0, 0, ONE, 0, 0, 0, ONE), 0);                       // secant
    send_query(make_query(3 * ONE, -ONE, -ONE, ONE, 0, 0, 5 * ONE), 2);       // diagonal secant
    send_query(make_query(5, 7, 0, 0, 0, 0, ONE), 0);                         // zero direction
    send_query(make_query(0, 0, 0, 0, 0, 0, 0), 0);                           // all zero
    send_query(make_query(0, 0, 1, 0, 0, 0, 0), 0);                           // zero radius tangent
    send_query(make_query(0, 0, 1, 1, 0, 0, 1), 0);                           // tiny numbers
    send_query(make_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff), 3);
    send_query(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff), 0);
    send_query(make_query(32'h8000_0000, 0, ONE, 0, 32'h7fff_ffff, 0, 31'h7fff_ffff), 0);
    send_query(make_query(0, 0, ONE, 0, 32'h7fff_0000, 0, 31'h7fff_ffff), 0); // clips right
    send_query(make_query(0, 0, -1, 0, 32'h8000_0000, 0, 31'h7fff_ffff), 0);  // clips left
    send_query(make_query(0, 0, 32'h7fff_ffff, 1, 0, 0, 31'h7fff_ffff), 1);
    send_query(make_query(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          32'hffff_ffff, 32'hffff_ffff, 31'h4000_0000), 0);
    send_query(make_query(10 * ONE, 3 * ONE, 0, ONE, 10 * ONE, 0, 0), 0);     // point radius
    send_query(make_query(-4 * ONE, 0, 3, 4, 0, 0, 3 * ONE), 0);
    wait_drained();
  endtask

  task automatic test_random();
    query_t q;
    int kind;
    for (int n = 0; n < 1100; n++) begin
      kind = $urandom_range(9);
      q = make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     RADW'($urandom));
      case (kind)
        0, 1: begin
          // raw noise over the full word range
        end
        2, 3, 4: begin
          // line through a point near the centre: usually a secant, random content
          q.center_x = $signed($urandom) >>> $urandom_range(16);
          q.center_y = $signed($urandom) >>> $urandom_range(16);
          q.radius   = RADW'($urandom_range(31'h3fff_ffff, 1) >> $urandom_range(14));
          q.line_px  = q.center_x + ($signed($urandom) >>> (16 + $urandom_range(15)));
          q.line_py  = q.center_y + ($signed($urandom) >>> (16 + $urandom_range(15)));
          q.line_dx  = $signed($urandom) >>> $urandom_range(24);
          q.line_dy  = $signed($urandom) >>> $urandom_range(24);
        end
        5: begin
          // axis-aligned tangent lines
          q.center_x = $signed($urandom) >>> 4;
          q.center_y = $signed($urandom) >>> 4;
          q.radius   = RADW'($urandom_range(31'h0fff_ffff));
          q.line_dx  = $signed($urandom) >>> $urandom_range(20);
          q.line_dy  = 0;
          q.line_px  = $signed($urandom) >>> 4;
          q.line_py  = $urandom_range(1) ? q.center_y + int'(q.radius)
                                         : q.center_y - int'(q.radius);
        end
        6: begin
          // small coordinates, any outcome
          q.line_px  = $signed($urandom) >>> 24;
          q.line_py  = $signed($urandom) >>> 24;
          q.line_dx  = $signed($urandom) >>> 26;
          q.line_dy  = $signed($urandom) >>> 26;
          q.center_x = $signed($urandom) >>> 24;
          q.center_y = $signed($urandom) >>> 24;
          q.radius   = RADW'($urandom_range(300));
        end
        7: begin
          // degenerate or single-axis directions
          if ($urandom_range(1)) q.line_dx = 0;
          if ($urandom_range(1)) q.line_dy = 0;
        end
        default: begin
          // huge radius: points tend to saturate
          q.radius = RADW'(32'h7000_0000 | $urandom);
        end
      endcase
      send_query(q, pick_gap());
    end
  endtask

  // sender holds off until the pipeline is empty, then a burst follows
  task automatic test_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int n = 0; n < 20; n++)
      send_query(make_query($urandom, $urandom, $urandom >> 8, $urandom >> 8,
                            $urandom, $urandom, RADW'($urandom)), 0);
    start <= 1'b0;
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    query = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
